// ===== design/two_stack_text_cursor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text cursor
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_STACK_TEXT_CURSOR_MACROS_SVH
`define TWO_STACK_TEXT_CURSOR_MACROS_SVH

`ifndef SYNTHESIS
`define TSTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TSTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/tstc_pkg.sv =====
// ----------------------------------------------------------------------------
// Text cursor package
// Field widths, action and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tstc_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned ActWidth     = 3;
  localparam int unsigned CharWidth    = 8;
  localparam int unsigned LenWidth     = 11;
  localparam int unsigned StatWidth    = 2;

  typedef enum logic [ActWidth-1:0] {
    ACT_INSERT     = 3'd0,
    ACT_LEFT       = 3'd1,
    ACT_RIGHT      = 3'd2,
    ACT_DEL_BEFORE = 3'd3,
    ACT_DEL_AFTER  = 3'd4,
    ACT_HOME       = 3'd5,
    ACT_END        = 3'd6
  } action_e;

  typedef enum logic [StatWidth-1:0] {
    STS_DONE  = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFER,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic exec;      // apply the accepted action
    logic xfer;      // move one character between stacks
    logic to_right;  // transfer direction: left stack onto right stack
    logic finish;    // load the result register and the top caches
  } cmd_t;

  typedef struct packed {
    logic left_empty;
    logic right_empty;
    logic xfer_done;
  } stat_t;

endpackage

// ===== design/tstc_in_if.sv =====
// ----------------------------------------------------------------------------
// Text cursor action channel
// Valid/ready channel that carries one editing action per transaction.
// ----------------------------------------------------------------------------
interface tstc_in_if;
  import tstc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ActWidth-1:0]  action;
  logic [CharWidth-1:0] new_char;

  modport source (output valid, action, new_char, input ready);
  modport sink (input valid, action, new_char, output ready);
endinterface

// ===== design/tstc_out_if.sv =====
// ----------------------------------------------------------------------------
// Text cursor result channel
// Valid/ready channel that carries the counts and neighbor characters.
// ----------------------------------------------------------------------------
interface tstc_out_if;
  import tstc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [LenWidth-1:0]  left_length;
  logic [LenWidth-1:0]  right_length;
  logic [CharWidth-1:0] char_before;
  logic                 before_valid;
  logic [CharWidth-1:0] char_after;
  logic                 after_valid;
  logic [StatWidth-1:0] status;

  modport source (
    output valid, left_length, right_length, char_before, before_valid,
           char_after, after_valid, status,
    input  ready
  );
  modport sink (
    input  valid, left_length, right_length, char_before, before_valid,
           char_after, after_valid, status,
    output ready
  );
endinterface

// ===== design/two_stack_text_cursor.sv =====
// Insert, move and delete go from acceptance to the done state, which loads the result
// register once the output slot is free. Home and end that have characters to move pass
// through the transfer state first; with nothing to move they go to the done state directly.
// A new action is taken only in the idle state, so the next one waits until the result is
// loaded. Each stack memory has a registered read port; a transfer moves one character per cycle.
// Reset clears both counts and the controller; the stack memories are not cleared.
// ----------------------------------------------------------------------------
// Two-stack text cursor
// Line-editing cursor kept as a gap buffer of two character stacks.
// ----------------------------------------------------------------------------
module two_stack_text_cursor #(
  parameter int unsigned Depth = tstc_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tstc_in_if.sink   in_i,
  tstc_out_if.source out_o
);
  import tstc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tstc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .action_i    (in_i.action),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tstc_datapath #(
    .Depth (Depth)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (in_i.action),
    .new_char_i     (in_i.new_char),
    .left_length_o  (out_o.left_length),
    .right_length_o (out_o.right_length),
    .char_before_o  (out_o.char_before),
    .before_valid_o (out_o.before_valid),
    .char_after_o   (out_o.char_after),
    .after_valid_o  (out_o.after_valid),
    .status_o       (out_o.status)
  );

endmodule

// ===== design/tstc_datapath.sv =====
// ----------------------------------------------------------------------------
// Text cursor datapath
// The two character stacks, their counts, cached top characters and the
// result register.
// ----------------------------------------------------------------------------
`include "two_stack_text_cursor_macros.svh"

module tstc_datapath #(
  parameter int unsigned Depth = tstc_pkg::DefaultDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tstc_pkg::cmd_t                 cmd_i,
  output tstc_pkg::stat_t                stat_o,
  input  logic [tstc_pkg::ActWidth-1:0]  action_i,
  input  logic [tstc_pkg::CharWidth-1:0] new_char_i,
  output logic [tstc_pkg::LenWidth-1:0]  left_length_o,
  output logic [tstc_pkg::LenWidth-1:0]  right_length_o,
  output logic [tstc_pkg::CharWidth-1:0] char_before_o,
  output logic                           before_valid_o,
  output logic [tstc_pkg::CharWidth-1:0] char_after_o,
  output logic                           after_valid_o,
  output logic [tstc_pkg::StatWidth-1:0] status_o
);
  import tstc_pkg::*;

  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth  = $clog2(Depth + 1);
  localparam logic [CntWidth:0]   DepthSum = (CntWidth + 1)'(Depth);
  localparam logic [CntWidth-1:0] CntOne   = CntWidth'(1);

  logic [CharWidth-1:0] left_mem  [Depth];
  logic [CharWidth-1:0] right_mem [Depth];

  logic [CntWidth-1:0]  lc_q, lc_d, rc_q, rc_d;
  status_e              status_q, status_d;
  logic                 pend_q, pend_d;
  logic [CntWidth:0]    cnt_sum;
  logic [CntWidth:0]    xfer_total;

  logic                 l_we, r_we;
  logic [AddrWidth-1:0] l_waddr, r_waddr, l_raddr, r_raddr;
  logic [CharWidth-1:0] l_wdata, r_wdata;
  logic                 l_xfer_rd, r_xfer_rd;
  logic [CntWidth-1:0]  l_rcnt, r_rcnt, l_rptr, r_rptr;
  logic [CharWidth-1:0] l_rdata_q, r_rdata_q, l_rd, r_rd;
  logic                 l_byp_q, l_byp_d, r_byp_q, r_byp_d;
  logic [CharWidth-1:0] l_byp_data_q, r_byp_data_q;
  logic [CharWidth-1:0] top_l_q, top_r_q;

  logic [LenWidth-1:0]  left_len_q, right_len_q;
  logic [CharWidth-1:0] char_before_q, char_after_q;
  logic                 before_valid_q, after_valid_q;
  logic [StatWidth-1:0] status_out_q;

  assign cnt_sum    = {1'b0, lc_q} + {1'b0, rc_q};
  assign xfer_total = cnt_sum + {{CntWidth{1'b0}}, pend_q};

  // A read that hits the address written in the same cycle takes the
  // written byte instead of the stale array word.
  assign l_rd = l_byp_q ? l_byp_data_q : l_rdata_q;
  assign r_rd = r_byp_q ? r_byp_data_q : r_rdata_q;

  always_comb begin
    lc_d      = lc_q;
    rc_d      = rc_q;
    status_d  = status_q;
    pend_d    = 1'b0;
    l_we      = 1'b0;
    l_waddr   = lc_q[AddrWidth-1:0];
    l_wdata   = new_char_i;
    r_we      = 1'b0;
    r_waddr   = rc_q[AddrWidth-1:0];
    r_wdata   = top_l_q;
    l_xfer_rd = 1'b0;
    r_xfer_rd = 1'b0;

    if (cmd_i.exec) begin
      status_d = STS_DONE;
      case (action_e'(action_i))
        ACT_INSERT: begin
          if (cnt_sum >= DepthSum) begin
            status_d = STS_FULL;
          end else begin
            l_we    = 1'b1;
            l_wdata = new_char_i;
            lc_d    = lc_q + CntOne;
          end
        end
        ACT_LEFT: begin
          if (lc_q == '0) begin
            status_d = STS_EMPTY;
          end else begin
            r_we    = 1'b1;
            r_wdata = top_l_q;
            rc_d    = rc_q + CntOne;
            lc_d    = lc_q - CntOne;
          end
        end
        ACT_RIGHT: begin
          if (rc_q == '0) begin
            status_d = STS_EMPTY;
          end else begin
            l_we    = 1'b1;
            l_wdata = top_r_q;
            lc_d    = lc_q + CntOne;
            rc_d    = rc_q - CntOne;
          end
        end
        ACT_DEL_BEFORE: begin
          if (lc_q == '0) begin
            status_d = STS_EMPTY;
          end else begin
            lc_d = lc_q - CntOne;
          end
        end
        ACT_DEL_AFTER: begin
          if (rc_q == '0) begin
            status_d = STS_EMPTY;
          end else begin
            rc_d = rc_q - CntOne;
          end
        end
        default: ;
      endcase
    end

    // Transfers run as a two-step pipeline: the source top is read in one
    // cycle and pushed on the destination stack in the next.
    if (cmd_i.xfer) begin
      if (cmd_i.to_right) begin
        if (lc_q != '0) begin
          l_xfer_rd = 1'b1;
          lc_d      = lc_q - CntOne;
          pend_d    = 1'b1;
        end
        if (pend_q) begin
          r_we    = 1'b1;
          r_wdata = l_rd;
          rc_d    = rc_q + CntOne;
        end
      end else begin
        if (rc_q != '0) begin
          r_xfer_rd = 1'b1;
          rc_d      = rc_q - CntOne;
          pend_d    = 1'b1;
        end
        if (pend_q) begin
          l_we    = 1'b1;
          l_wdata = r_rd;
          lc_d    = lc_q + CntOne;
        end
      end
    end
  end

  // Outside a transfer each port reads the top that the new count exposes.
  assign l_rcnt  = l_xfer_rd ? lc_q : lc_d;
  assign r_rcnt  = r_xfer_rd ? rc_q : rc_d;
  assign l_rptr  = l_rcnt - CntOne;
  assign r_rptr  = r_rcnt - CntOne;
  assign l_raddr = l_rptr[AddrWidth-1:0];
  assign r_raddr = r_rptr[AddrWidth-1:0];
  assign l_byp_d = l_we && (l_waddr == l_raddr);
  assign r_byp_d = r_we && (r_waddr == r_raddr);

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      left_mem[l_waddr] <= l_wdata;
    end
    l_rdata_q <= left_mem[l_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      right_mem[r_waddr] <= r_wdata;
    end
    r_rdata_q <= right_mem[r_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q     <= '0;
      rc_q     <= '0;
      status_q <= STS_DONE;
      pend_q   <= 1'b0;
      l_byp_q  <= 1'b0;
      r_byp_q  <= 1'b0;
    end else begin
      lc_q     <= lc_d;
      rc_q     <= rc_d;
      status_q <= status_d;
      pend_q   <= pend_d;
      l_byp_q  <= l_byp_d;
      r_byp_q  <= r_byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_byp_data_q <= l_wdata;
    r_byp_data_q <= r_wdata;
    if (cmd_i.finish) begin
      top_l_q        <= l_rd;
      top_r_q        <= r_rd;
      left_len_q     <= LenWidth'(lc_q);
      right_len_q    <= LenWidth'(rc_q);
      before_valid_q <= (lc_q != '0);
      after_valid_q  <= (rc_q != '0);
      char_before_q  <= (lc_q != '0) ? l_rd : '0;
      char_after_q   <= (rc_q != '0) ? r_rd : '0;
      status_out_q   <= status_q;
    end
  end

  assign stat_o.left_empty  = (lc_q == '0);
  assign stat_o.right_empty = (rc_q == '0);
  assign stat_o.xfer_done   = cmd_i.to_right ? (lc_q == '0) : (rc_q == '0);

  assign left_length_o  = left_len_q;
  assign right_length_o = right_len_q;
  assign char_before_o  = char_before_q;
  assign before_valid_o = before_valid_q;
  assign char_after_o   = char_after_q;
  assign after_valid_o  = after_valid_q;
  assign status_o       = status_out_q;

  `TSTC_ASSERT(a_fill_bound, clk_i, rst_ni, cnt_sum <= DepthSum, "text longer than depth")
  `TSTC_ASSERT(a_one_write, clk_i, rst_ni, !(l_we && r_we), "both stacks written at once")
  `TSTC_ASSERT_NEXT(a_xfer_keeps, clk_i, rst_ni, cmd_i.xfer,
    xfer_total == $past(xfer_total), "transfer lost a character")

endmodule

// ===== design/tstc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text cursor controller
// Sequences one action: execute, optional stack transfer, result load.
// ----------------------------------------------------------------------------
`include "two_stack_text_cursor_macros.svh"

module tstc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tstc_pkg::ActWidth-1:0] action_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  tstc_pkg::stat_t               stat_i,
  output tstc_pkg::cmd_t                cmd_o
);
  import tstc_pkg::*;

  state_e state_q, state_d;
  logic   dir_q, dir_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;
  logic   is_home, is_end;

  assign is_home   = (action_e'(action_i) == ACT_HOME);
  assign is_end    = (action_e'(action_i) == ACT_END);
  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_home && !stat_i.left_empty) begin
            state_d = ST_XFER;
          end else if (is_end && !stat_i.right_empty) begin
            state_d = ST_XFER;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_XFER: begin
        if (stat_i.xfer_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.exec   = 1'b0;
    cmd_o.xfer   = 1'b0;
    cmd_o.finish = 1'b0;
    cmd_o.to_right = dir_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.exec = in_valid_i;
      end
      ST_XFER: cmd_o.xfer = 1'b1;
      ST_DONE: cmd_o.finish = slot_free;
      default: ;
    endcase
  end

  assign dir_d       = accept ? is_home : dir_q;
  assign out_valid_d = cmd_o.finish || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TSTC_ASSERT_NEXT(a_home_moves, clk_i, rst_ni,
    accept && is_home && !stat_i.left_empty, state_q == ST_XFER,
    "home skipped the transfer")
  `TSTC_ASSERT_NEXT(a_result_shown, clk_i, rst_ni, cmd_o.finish, out_valid_q,
    "result not presented")
  `TSTC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q,
    "result dropped while stalled")

endmodule
